### src/fmp_pkg.sv
// Shared constants and controller-to-datapath types for the Fibonacci matrix-power block.
`timescale 1ns / 1ps
package fmp_pkg;

  localparam int IndexWidth = 7;
  localparam int ValueWidth = 63;
  localparam int MulWidth   = 32;
  localparam int ProdWidth  = 2 * MulWidth;
  localparam int BitCntWidth = $clog2(IndexWidth);

  // Largest index whose Fibonacci number fits in the 63-bit result.
  localparam logic [IndexWidth-1:0] FIB_MAX_INDEX = IndexWidth'(92);
  localparam logic [BitCntWidth-1:0] TOP_BIT    = BitCntWidth'(IndexWidth - 1);

  // Steps of one squaring pass through the shared multiplier.
  localparam logic [2:0] STEP_SQ_A   = 3'd0;  // a*a, also latch a+c
  localparam logic [2:0] STEP_SQ_B   = 3'd1;  // b*b
  localparam logic [2:0] STEP_SQ_C   = 3'd2;  // c*c
  localparam logic [2:0] STEP_CROSS  = 3'd3;  // b*(a+c)
  localparam logic [2:0] STEP_UPDATE = 3'd4;  // write the squared matrix back

  typedef struct packed {
    logic                   load;      // take a new request into the datapath
    logic                   square;    // run squaring step 'step'
    logic [2:0]             step;
    logic                   mul_q;     // multiply the accumulator by the base matrix
    logic [BitCntWidth-1:0] bit_sel;   // exponent bit to report
    logic                   out_load;  // capture the result into the output register
  } cmd_t;

  typedef struct packed {
    logic skip;     // index zero or above the representable range
    logic bit_set;  // selected exponent bit
  } status_t;

endpackage

### src/fmp_datapath.sv
// Datapath: symmetric 2x2 accumulator, shared 32x32 multiplier and result register.
`timescale 1ns / 1ps
module fmp_datapath
  import fmp_pkg::*;
(
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [IndexWidth-1:0] index,
  output status_t               status,
  output logic [ValueWidth-1:0] fib_value,
  output logic                  overflow
);

  // Q^k is symmetric: a = e00, b = e01 = e10, c = e11.
  logic [ValueWidth-1:0] a, b, c;
  logic [ValueWidth-1:0] sum_ac, ta, tb, tc;
  logic [ProdWidth-1:0]  prod;
  logic [IndexWidth-1:0] expo;
  logic                  idx_zero, idx_ovf;

  logic [MulWidth-1:0]   mul_x, mul_y;
  logic [ProdWidth-1:0]  mul_p;

  // For every index that fits, each operand is a Fibonacci number (or a sum of two)
  // below 2^32, so the low 32 bits carry the full value.
  always_comb begin
    case (cmd.step)
      STEP_SQ_A: begin
        mul_x = a[MulWidth-1:0];
        mul_y = a[MulWidth-1:0];
      end
      STEP_SQ_B: begin
        mul_x = b[MulWidth-1:0];
        mul_y = b[MulWidth-1:0];
      end
      STEP_SQ_C: begin
        mul_x = c[MulWidth-1:0];
        mul_y = c[MulWidth-1:0];
      end
      default: begin
        mul_x = b[MulWidth-1:0];
        mul_y = sum_ac[MulWidth-1:0];
      end
    endcase
  end

  // Both operands are zero-extended 32-bit values, so this is a 32x32 product.
  assign mul_p = ProdWidth'(mul_x) * ProdWidth'(mul_y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a        <= ValueWidth'(1);
      b        <= '0;
      c        <= ValueWidth'(1);
      expo     <= index - IndexWidth'(1);
      idx_zero <= (index == '0);
      idx_ovf  <= (index > FIB_MAX_INDEX);
    end else if (cmd.square) begin
      case (cmd.step)
        STEP_SQ_A: begin
          prod   <= mul_p;
          sum_ac <= a + c;
        end
        STEP_SQ_B: begin
          ta   <= prod[ValueWidth-1:0];
          prod <= mul_p;
        end
        STEP_SQ_C: begin
          tb   <= prod[ValueWidth-1:0];
          prod <= mul_p;
        end
        STEP_CROSS: begin
          tc   <= prod[ValueWidth-1:0];
          prod <= mul_p;
        end
        default: begin
          a <= ta + tb;
          b <= prod[ValueWidth-1:0];
          c <= tb + tc;
        end
      endcase
    end else if (cmd.mul_q) begin
      a <= a + b;
      b <= a;
      c <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fib_value <= (idx_zero || idx_ovf) ? '0 : a;
      overflow  <= idx_ovf;
    end
  end

  assign status.skip    = idx_zero | idx_ovf;
  assign status.bit_set = expo[cmd.bit_sel];

endmodule

### src/fmp_ctrl.sv
// Controller: sequences the square-and-multiply steps and owns both handshakes.
`timescale 1ns / 1ps
module fmp_ctrl
  import fmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SQUARE = 2'd2;
  localparam logic [1:0] S_MULQ   = 2'd3;

  logic [1:0]             state, state_next;
  logic                   finish, finish_next;
  logic [2:0]             step, step_next;
  logic [BitCntWidth-1:0] bit_cnt, bit_cnt_next;
  logic                   out_free;

  assign in_stall = (state != S_IDLE) || finish;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    finish_next  = finish;
    step_next    = step;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    cmd.step     = step;
    cmd.bit_sel  = bit_cnt;

    if (finish) begin
      if (out_free) begin
        cmd.out_load = 1'b1;
        finish_next  = 1'b0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_CHECK;
          end
        end
        S_CHECK: begin
          step_next    = STEP_SQ_A;
          bit_cnt_next = TOP_BIT;
          if (status.skip) begin
            state_next  = S_IDLE;
            finish_next = 1'b1;
          end else begin
            state_next = S_SQUARE;
          end
        end
        S_SQUARE: begin
          cmd.square = 1'b1;
          if (step == STEP_UPDATE) begin
            step_next = STEP_SQ_A;
            if (status.bit_set) begin
              state_next = S_MULQ;
            end else if (bit_cnt == '0) begin
              state_next  = S_IDLE;
              finish_next = 1'b1;
            end else begin
              bit_cnt_next = bit_cnt - BitCntWidth'(1);
            end
          end else begin
            step_next = step + 3'd1;
          end
        end
        S_MULQ: begin
          cmd.mul_q = 1'b1;
          if (bit_cnt == '0) begin
            state_next  = S_IDLE;
            finish_next = 1'b1;
          end else begin
            bit_cnt_next = bit_cnt - BitCntWidth'(1);
            state_next   = S_SQUARE;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      finish    <= 1'b0;
      step      <= STEP_SQ_A;
      bit_cnt   <= TOP_BIT;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      finish  <= finish_next;
      step    <= step_next;
      bit_cnt <= bit_cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register loaded while a stalled result waits");

  // An accepted request always goes to the range check next.
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CHECK))
    else $error("accepted request did not reach the range check");

  // The exponent walk never leaves the index width.
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQUARE || state == S_MULQ) |-> (bit_cnt <= TOP_BIT))
    else $error("exponent bit counter out of range");

  // The step counter stays within the five steps of a squaring pass.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQUARE) |-> (step <= STEP_UPDATE))
    else $error("squaring step counter out of range");

  // A result that is not taken stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !cmd.out_load) |=> out_valid)
    else $error("stalled result dropped");

  // Whenever the controller idles, the step counter is back at the first squaring step.
  a_step_rewound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (step == STEP_SQ_A))
    else $error("step counter not rewound in idle");

endmodule

### src/fibonacci_matrix_power.sv
// Top level of the Fibonacci-by-matrix-power block: controller plus datapath.
`timescale 1ns / 1ps
// Computes F(index) for a 7-bit index, with F(0) = 0 and F(1) = 1.
// Input channel: in_valid / in_stall with the index field. A request is taken at a
// rising edge where in_valid is high and in_stall is low. in_stall is high while a
// request is being worked on, so one request is in flight at a time.
// Output channel: out_valid / out_stall with fib_value and overflow. A result
// sits in the output register until the receiver takes it; the next request is
// accepted while that result still waits.
// Work: the accumulator starts as the identity and walks the seven bits of
// index-1 from the top. Each bit takes a squaring pass through the single
// shared 32x32 multiplier (three squares, one cross product, one write-back),
// plus an addition step when the bit is set.
// Index zero and indexes above 92 skip the walk; above 92, overflow is 1 and
// fib_value is 0.
// A new request can be taken in the cycle after the result is loaded.
// If the receiver stalls, the finished result holds in the controller until the
// output register frees, and no new request is taken meanwhile.
// Reset (rst, synchronous) returns the controller to idle and drops any result.
module fibonacci_matrix_power
  import fmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IndexWidth-1:0] index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ValueWidth-1:0] fib_value,
  output logic                  overflow
);

  cmd_t    cmd;
  status_t status;

  // The controller decides step by step; the datapath only follows commands.
  fmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Matrix registers, shared multiplier and the result register.
  fmp_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .index     (index),
    .status    (status),
    .fib_value (fib_value),
    .overflow  (overflow)
  );

endmodule
